// ----- sv/dtmh_pkg.sv -----
// ----------------------------------------------------------------------------
// dtmh_pkg
// Shared types, constants and helpers for the deadline timer min-heap core.
// ----------------------------------------------------------------------------
package dtmh_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W      = CNT_W + 1;

  localparam int SEC_W   = 32;
  localparam int NSEC_W  = 30;
  localparam int USEC_W  = 32;
  localparam int TAG_W   = 16;
  localparam int OUTCNT_W = 7;

  localparam int QUOT_W  = 13;   // wait_usec / 10^6 stays below 2^13
  localparam int UREM_W  = 20;   // remainder below 10^6

  // 10^6 = 2^6 * 15625: shift out 2^6, then multiply by ceil(2^40 / 15625)
  localparam int DIV_SHIFT   = 6;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 40;
  localparam int PROD_W      = USEC_W - DIV_SHIFT + RECIP_W;

  localparam logic [RECIP_W-1:0] USEC_RECIP    = 27'd70368745;
  localparam logic [UREM_W-1:0]  USEC_PER_SEC  = 20'd1000000;
  localparam logic [NSEC_W:0]    NSEC_PER_SEC  = 31'd1000000000;
  localparam logic [9:0]         NSEC_PER_USEC = 10'd1000;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_EXPIRE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic              op;
    logic [SEC_W-1:0]  now_sec;
    logic [NSEC_W-1:0] now_nsec;
    logic [SEC_W-1:0]  wait_sec;
    logic [USEC_W-1:0] wait_usec;
    logic [TAG_W-1:0]  task_tag;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic              fired;
    logic [TAG_W-1:0]  fired_tag;
    logic [SEC_W-1:0]  fired_sec;
    logic [NSEC_W-1:0] fired_nsec;
    logic              arm_changed;
    logic [SEC_W-1:0]  armed_sec_out;
    logic [NSEC_W-1:0] armed_nsec_out;
    logic [OUTCNT_W-1:0] task_count;
  } out_item_t;

  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [NSEC_W-1:0] nsec;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [SEC_W-1:0]  now_sec;
    logic [NSEC_W-1:0] now_nsec;
    logic [SEC_W-1:0]  wait_sec;
    logic [USEC_W-1:0] wait_usec;
  } calc_req_t;

  typedef struct packed {
    logic              done;
    logic [SEC_W-1:0]  sec;
    logic [NSEC_W-1:0] nsec;
  } calc_rsp_t;

  // strictly earlier by (seconds, nanoseconds)
  function automatic logic earlier(input logic [SEC_W-1:0] s1, input logic [NSEC_W-1:0] n1,
                                   input logic [SEC_W-1:0] s2, input logic [NSEC_W-1:0] n2);
    earlier = (s1 < s2) || ((s1 == s2) && (n1 < n2));
  endfunction

endpackage

// ----- sv/dtmh_heap_ram.sv -----
// ----------------------------------------------------------------------------
// dtmh_heap_ram
// Heap entry storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dtmh_heap_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [dtmh_pkg::ADDR_W-1:0] wr_addr,
  input  dtmh_pkg::entry_t          wr_data,
  input  logic [dtmh_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [dtmh_pkg::ADDR_W-1:0] rd_addr_b,
  output dtmh_pkg::entry_t          rd_data_a,
  output dtmh_pkg::entry_t          rd_data_b
);

  dtmh_pkg::entry_t mem [dtmh_pkg::HEAP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- sv/dtmh_deadline_calc.sv -----
// ----------------------------------------------------------------------------
// dtmh_deadline_calc
// Deadline = now + wait: reciprocal multiply of microseconds by 1/10^6, then
// scale the remainder to nanoseconds and fold the carries into seconds.
// ----------------------------------------------------------------------------
module dtmh_deadline_calc (
  input  logic                clk,
  input  logic                rst,
  input  dtmh_pkg::calc_req_t req,
  output dtmh_pkg::calc_rsp_t rsp
);

  typedef enum logic [2:0] {
    C_IDLE,
    C_QUOT,
    C_REM,
    C_MUL,
    C_SUM,
    C_NORM,
    C_FIN
  } cstate_t;

  cstate_t                         state;
  logic [dtmh_pkg::SEC_W-1:0]      now_sec;
  logic [dtmh_pkg::NSEC_W-1:0]     now_nsec;
  logic [dtmh_pkg::SEC_W-1:0]      wait_sec;
  logic [dtmh_pkg::USEC_W-1:0]     rem;
  logic [dtmh_pkg::QUOT_W-1:0]     quot;
  logic [dtmh_pkg::NSEC_W-1:0]     prod;
  logic [dtmh_pkg::NSEC_W:0]       sum_n;
  logic [dtmh_pkg::SEC_W-1:0]      sec;
  logic                            norm_cnt;

  logic [dtmh_pkg::PROD_W-1:0]     recip_prod;
  logic [dtmh_pkg::USEC_W-1:0]     back;
  logic [dtmh_pkg::NSEC_W-1:0]     mult;

  assign recip_prod = {{(dtmh_pkg::PROD_W-dtmh_pkg::USEC_W+dtmh_pkg::DIV_SHIFT){1'b0}},
                       rem[dtmh_pkg::USEC_W-1:dtmh_pkg::DIV_SHIFT]}
                      * {{(dtmh_pkg::PROD_W-dtmh_pkg::RECIP_W){1'b0}}, dtmh_pkg::USEC_RECIP};
  assign back  = {{(dtmh_pkg::USEC_W-dtmh_pkg::QUOT_W){1'b0}}, quot}
                 * {{(dtmh_pkg::USEC_W-dtmh_pkg::UREM_W){1'b0}}, dtmh_pkg::USEC_PER_SEC};
  assign mult  = {{(dtmh_pkg::NSEC_W-dtmh_pkg::UREM_W){1'b0}}, rem[dtmh_pkg::UREM_W-1:0]}
                 * {{(dtmh_pkg::NSEC_W-10){1'b0}}, dtmh_pkg::NSEC_PER_USEC};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (req.start) begin
            now_sec  <= req.now_sec;
            now_nsec <= req.now_nsec;
            wait_sec <= req.wait_sec;
            rem      <= req.wait_usec;
            state    <= C_QUOT;
          end
        end
        C_QUOT: begin
          // exact for every 32-bit microsecond count
          quot  <= recip_prod[dtmh_pkg::PROD_W-1:dtmh_pkg::RECIP_SHIFT];
          state <= C_REM;
        end
        C_REM: begin
          rem   <= rem - back;
          state <= C_MUL;
        end
        C_MUL: begin
          prod  <= mult;
          state <= C_SUM;
        end
        C_SUM: begin
          sum_n    <= {1'b0, now_nsec} + {1'b0, prod};
          sec      <= now_sec + wait_sec
                      + {{(dtmh_pkg::SEC_W-dtmh_pkg::QUOT_W){1'b0}}, quot};
          norm_cnt <= 1'b0;
          state    <= C_NORM;
        end
        C_NORM: begin
          // at most two carries into seconds
          if (sum_n >= dtmh_pkg::NSEC_PER_SEC) begin
            sum_n <= sum_n - dtmh_pkg::NSEC_PER_SEC;
            sec   <= sec + 1'b1;
          end
          norm_cnt <= 1'b1;
          if (norm_cnt) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (state == C_FIN);
  assign rsp.sec  = sec;
  assign rsp.nsec = sum_n[dtmh_pkg::NSEC_W-1:0];

endmodule

// ----- sv/deadline_timer_min_heap_core.sv -----
// ----------------------------------------------------------------------------
// deadline_timer_min_heap_core
// Deadline queue held as a binary min-heap with one armed deadline.
//
//   channel | valid    | stall     | payload
//   input   | in_valid | in_stall  | in_data  (dtmh_pkg::in_item_t)
//   output  | out_valid| out_stall | out_data (dtmh_pkg::out_item_t)
//
// Add: the deadline unit computes the deadline, then the entry walks up the heap,
// a read and a compare state per level, and is placed (at most 6 levels for 64
// entries); a full heap skips the walk. Expiry: the last entry is fetched, walks
// down a read and a compare state per level, and is placed; the heap memory's
// registered read port sets the read-then-compare step. Every word then posts a
// registered result, held while a waiting result is stalled; the next word enters
// behind a waiting result. Reset clears count and armed state.
// ----------------------------------------------------------------------------
module deadline_timer_min_heap_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtmh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dtmh_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t                          state;
  logic [dtmh_pkg::CNT_W-1:0]      count;
  logic [dtmh_pkg::IDX_W-1:0]      hole;
  logic                            op;
  dtmh_pkg::entry_t                ent;
  dtmh_pkg::entry_t                top;
  logic                            armed_valid;
  logic [dtmh_pkg::SEC_W-1:0]      armed_sec;
  logic [dtmh_pkg::NSEC_W-1:0]     armed_nsec;
  dtmh_pkg::status_t               res_status;
  logic                            res_fired;
  dtmh_pkg::entry_t                res_ent;
  logic [dtmh_pkg::TAG_W-1:0]      in_data_tag;

  dtmh_pkg::calc_req_t             calc_req;
  dtmh_pkg::calc_rsp_t             calc_rsp;

  logic                            wr_en;
  logic [dtmh_pkg::IDX_W-1:0]      wr_idx;
  dtmh_pkg::entry_t                wr_data;
  logic [dtmh_pkg::IDX_W-1:0]      rd_idx_a;
  logic [dtmh_pkg::IDX_W-1:0]      rd_idx_b;
  dtmh_pkg::entry_t                rd_a;
  dtmh_pkg::entry_t                rd_b;

  logic [dtmh_pkg::IDX_W-1:0]      count_ext;
  logic [dtmh_pkg::IDX_W-1:0]      parent_idx;
  logic [dtmh_pkg::IDX_W-1:0]      left_idx;
  logic                            use_right;
  dtmh_pkg::entry_t                child;
  logic [dtmh_pkg::IDX_W-1:0]      child_idx;
  logic                            up_move;
  logic                            dn_move;
  logic                            accept;
  logic                            fin_go;
  logic                            offer;
  logic                            arm_set;
  logic                            arm_keep;
  logic                            changed;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE);
  assign count_ext  = {1'b0, count};
  assign parent_idx = hole >> 1;
  assign left_idx   = hole << 1;
  assign use_right  = (left_idx < count_ext)
                      && dtmh_pkg::earlier(rd_b.sec, rd_b.nsec, rd_a.sec, rd_a.nsec);
  assign child      = use_right ? rd_b : rd_a;
  assign child_idx  = use_right ? left_idx + 1'b1 : left_idx;
  assign up_move    = dtmh_pkg::earlier(ent.sec, ent.nsec, rd_a.sec, rd_a.nsec);
  assign dn_move    = dtmh_pkg::earlier(child.sec, child.nsec, ent.sec, ent.nsec);
  assign fin_go     = (state == S_FIN) && (!out_valid || !out_stall);

  assign calc_req.start     = accept && (in_data.op == dtmh_pkg::OP_ADD);
  assign calc_req.now_sec   = in_data.now_sec;
  assign calc_req.now_nsec  = in_data.now_nsec;
  assign calc_req.wait_sec  = in_data.wait_sec;
  assign calc_req.wait_usec = in_data.wait_usec;

  dtmh_deadline_calc u_calc (
    .clk (clk),
    .rst (rst),
    .req (calc_req),
    .rsp (calc_rsp)
  );

  dtmh_heap_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (dtmh_pkg::ADDR_W'(wr_idx - 1'b1)),
    .wr_data   (wr_data),
    .rd_addr_a (dtmh_pkg::ADDR_W'(rd_idx_a - 1'b1)),
    .rd_addr_b (dtmh_pkg::ADDR_W'(rd_idx_b - 1'b1)),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // heap port control
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = hole;
    wr_data  = ent;
    rd_idx_a = hole;
    rd_idx_b = hole;
    case (state)
      S_IDLE: begin
        rd_idx_a = count_ext;  // last entry, for an expiry
      end
      S_UP_RD: begin
        rd_idx_a = parent_idx;
        wr_en    = (hole == dtmh_pkg::IDX_W'(1));
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_move ? rd_a : ent;
      end
      S_DN_RD: begin
        rd_idx_a = left_idx;
        rd_idx_b = left_idx + 1'b1;
        wr_en    = (left_idx > count_ext);
      end
      S_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = dn_move ? child : ent;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // arming decision at the end of an item
  always_comb begin
    offer    = !armed_valid || dtmh_pkg::earlier(ent.sec, ent.nsec, armed_sec, armed_nsec);
    arm_set  = 1'b0;
    arm_keep = 1'b1;
    changed  = 1'b0;
    if (op == dtmh_pkg::OP_ADD) begin
      if ((res_status == dtmh_pkg::ST_OK) && offer
          && (!armed_valid || dtmh_pkg::earlier(top.sec, top.nsec, armed_sec, armed_nsec))) begin
        arm_set = 1'b1;
        changed = 1'b1;
      end
    end else begin
      arm_keep = 1'b0;
      changed  = 1'b1;
      arm_set  = (count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      armed_valid <= 1'b0;
      armed_sec   <= '0;
      armed_nsec  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (wr_en && (wr_idx == dtmh_pkg::IDX_W'(1))) begin
        top <= wr_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= in_data.op;
            res_fired <= 1'b0;
            res_ent   <= '0;
            if (in_data.op == dtmh_pkg::OP_ADD) begin
              res_status <= dtmh_pkg::ST_OK;
              state      <= S_CALC;
            end else if (count == '0) begin
              res_status <= dtmh_pkg::ST_EMPTY;
              state      <= S_FIN;
            end else begin
              res_status <= dtmh_pkg::ST_OK;
              res_ent    <= top;
              res_fired  <= armed_valid && (top.sec == armed_sec)
                            && (top.nsec == armed_nsec);
              count      <= count - 1'b1;
              hole       <= dtmh_pkg::IDX_W'(1);
              state      <= (count == dtmh_pkg::CNT_W'(1)) ? S_FIN : S_DN_LAST;
            end
          end
        end
        S_CALC: begin
          if (calc_rsp.done) begin
            ent <= '{sec: calc_rsp.sec, nsec: calc_rsp.nsec, tag: in_data_tag};
            if (count >= dtmh_pkg::CNT_W'(dtmh_pkg::HEAP_DEPTH)) begin
              res_status <= dtmh_pkg::ST_FULL;
              state      <= S_FIN;
            end else begin
              count <= count + 1'b1;
              hole  <= count_ext + 1'b1;
              state <= S_UP_RD;
            end
          end
        end
        S_UP_RD: begin
          state <= (hole == dtmh_pkg::IDX_W'(1)) ? S_FIN : S_UP_CMP;
        end
        S_UP_CMP: begin
          // move the parent down into the hole, or drop the entry here
          if (up_move) begin
            hole  <= parent_idx;
            state <= S_UP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN_LAST: begin
          ent   <= rd_a;
          state <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= (left_idx > count_ext) ? S_FIN : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            hole  <= child_idx;
            state <= S_DN_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (arm_set) begin
              armed_valid <= 1'b1;
              armed_sec   <= top.sec;
              armed_nsec  <= top.nsec;
            end else if (!arm_keep) begin
              armed_valid <= 1'b0;
              armed_sec   <= '0;
              armed_nsec  <= '0;
            end
            out_data.status         <= res_status;
            out_data.fired          <= res_fired;
            out_data.fired_tag      <= res_ent.tag;
            out_data.fired_sec      <= res_ent.sec;
            out_data.fired_nsec     <= res_ent.nsec;
            out_data.arm_changed    <= changed;
            out_data.armed_sec_out  <= arm_set ? top.sec
                                       : (arm_keep ? armed_sec : '0);
            out_data.armed_nsec_out <= arm_set ? top.nsec
                                       : (arm_keep ? armed_nsec : '0);
            out_data.task_count     <= dtmh_pkg::OUTCNT_W'(count);
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // tag of the add in work; held with the rest of the word
  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_tag <= in_data.task_tag;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block took a word without going busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dtmh_pkg::CNT_W'(dtmh_pkg::HEAP_DEPTH))
    else $error("task count beyond heap depth");

  a_armed_needs_task: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && armed_valid |-> count != '0)
    else $error("armed with an empty heap");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_idx != '0) && (wr_idx <= count_ext))
    else $error("heap write outside live entries");
`endif

endmodule
